// ----- hw/rtl/feistel16_cbc_cipher_core_macros.svh -----
// Assertion macros shared by the cipher core RTL files.
// Depends on nothing; files that assert include it by name.
`ifndef FEISTEL16_CBC_CIPHER_CORE_MACROS_SVH
`define FEISTEL16_CBC_CIPHER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked assertion that is switched off while reset is asserted.
`define FEI16_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked in every cycle, reset included.
`define FEI16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FEI16_ASSERT(lbl, clk, rst_n, prop, msg)
`define FEI16_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/fei16_pkg.sv -----
// Package of the Feistel CBC cipher core: widths, reset values, register
// indexes, shared structs and the round functions. Depends on nothing.
package fei16_pkg;

	localparam int BLK_W      = 16;
	localparam int KEY_W      = 64;
	localparam int NUM_ROUNDS = 8;
	localparam int APB_AW     = 5;
	localparam int APB_DW     = 64;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = FIFO_AW + 1;

	localparam logic [KEY_W-1:0] KEYS_RESET = 64'h054D_32C9_6347_170F;
	localparam logic [BLK_W-1:0] IV_RESET   = 16'h1234;

	typedef enum logic [1:0] {
		REG_KEYS = 2'd0,
		REG_IV   = 2'd1,
		REG_MODE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [KEY_W-1:0] keys;
		logic [BLK_W-1:0] iv;
		logic             decrypt;
	} cfg_t;

	typedef struct packed {
		logic [BLK_W-1:0] result_block;
		logic             is_iv;
		logic             last;
	} res_t;

	// Up to two results written into the result queue in one cycle.
	typedef struct packed {
		logic [1:0] n;
		res_t       d0;
		res_t       d1;
	} push_t;

	function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] keys,
			input logic [2:0] r);
		return keys[8*r +: 8];
	endfunction

	function automatic logic [7:0] round_fn(input logic [7:0] h, input logic [7:0] k);
		logic [7:0] rot;
		rot = {h[6:0], h[7]};
		return (h ^ k) + rot;
	endfunction

	function automatic logic [BLK_W-1:0] enc_block(input logic [BLK_W-1:0] b,
			input logic [KEY_W-1:0] keys);
		logic [7:0] l;
		logic [7:0] r;
		logic [7:0] nr;
		l = b[15:8];
		r = b[7:0];
		for (int i = 0; i < NUM_ROUNDS; i++) begin
			nr = l ^ round_fn(r, key_byte(keys, 3'(i)));
			l  = r;
			r  = nr;
		end
		return {l, r};
	endfunction

	function automatic logic [BLK_W-1:0] dec_block(input logic [BLK_W-1:0] b,
			input logic [KEY_W-1:0] keys);
		logic [7:0] l;
		logic [7:0] r;
		logic [7:0] nl;
		l = b[15:8];
		r = b[7:0];
		for (int i = NUM_ROUNDS; i > 0; i--) begin
			nl = r ^ round_fn(l, key_byte(keys, 3'(i - 1)));
			r  = l;
			l  = nl;
		end
		return {l, r};
	endfunction

endpackage

// ----- hw/rtl/fei16_if.sv -----
// Stream interfaces of the cipher core: input blocks and results.
// Depends on fei16_pkg.
interface fei16_blk_if import fei16_pkg::*;;
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] data_block;
	logic             first_block;

	modport source(output valid, data_block, first_block, input ready);
	modport sink(input valid, data_block, first_block, output ready);
endinterface

interface fei16_res_if import fei16_pkg::*;;
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] result_block;
	logic             is_iv;
	logic             last;

	modport source(output valid, result_block, is_iv, last, input ready);
	modport sink(input valid, result_block, is_iv, last, output ready);
endinterface

// ----- hw/rtl/fei16_regs.sv -----
// APB configuration registers: round keys, IV and mode.
// Depends on fei16_pkg.
module fei16_regs import fei16_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output cfg_t              cfg
);

	reg_idx_t idx;
	logic     wr_en;
	cfg_t     cfg_q;

	// Registers sit on 8-byte boundaries.
	assign idx   = reg_idx_t'(paddr[APB_AW-1:3]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keys    <= KEYS_RESET;
			cfg_q.iv      <= IV_RESET;
			cfg_q.decrypt <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_KEYS: cfg_q.keys    <= pwdata;
				REG_IV:   cfg_q.iv      <= pwdata[BLK_W-1:0];
				REG_MODE: cfg_q.decrypt <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KEYS: prdata = cfg_q.keys;
			REG_IV:   prdata = {{(APB_DW-BLK_W){1'b0}}, cfg_q.iv};
			REG_MODE: prdata = {{(APB_DW-1){1'b0}}, cfg_q.decrypt};
			default:  prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/fei16_datapath.sv -----
// Input register, eight-round Feistel logic and CBC chain register.
// Depends on fei16_pkg and the assertion macro header.
`include "feistel16_cbc_cipher_core_macros.svh"
module fei16_datapath import fei16_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [BLK_W-1:0] in_data,
	input  logic             in_first,
	input  logic [CNT_W-1:0] space,
	output push_t            push
);

	logic             valid_s1;
	logic [BLK_W-1:0] data_s1;
	logic             first_s1;
	logic [BLK_W-1:0] chain_q;
	logic [BLK_W-1:0] chain_next;
	logic [BLK_W-1:0] ct;
	logic [BLK_W-1:0] pt;
	logic [1:0]       need;
	logic             fire;
	res_t             r0;
	res_t             r1;

	always_comb begin
		ct = enc_block(data_s1 ^ (first_s1 ? cfg.iv : chain_q), cfg.keys);
		pt = dec_block(data_s1, cfg.keys) ^ chain_q;
		r0 = '{result_block: ct, is_iv: 1'b0, last: 1'b1};
		r1 = '0;
		if (cfg.decrypt) begin
			chain_next = data_s1;
			need       = first_s1 ? 2'd0 : 2'd1;
			r0.result_block = pt;
		end else begin
			chain_next = ct;
			if (first_s1) begin
				need = 2'd2;
				r0   = '{result_block: cfg.iv, is_iv: 1'b1, last: 1'b0};
				r1   = '{result_block: ct, is_iv: 1'b0, last: 1'b1};
			end else begin
				need = 2'd1;
			end
		end
	end

	// The held block moves on once the queue has room for all its results.
	assign fire     = valid_s1 && ({1'b0, need} <= space);
	assign in_ready = !valid_s1 || fire;

	always_comb begin
		push.n  = fire ? need : 2'd0;
		push.d0 = r0;
		push.d1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			chain_q  <= IV_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (fire)
				chain_q <= chain_next;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= in_data;
			first_s1 <= in_first;
		end
	end

	`FEI16_ASSERT(a_chain_hold, clk, arst_n, !fire |=> $stable(chain_q), "chain moved without a block")
	`FEI16_ASSERT(a_dec_first_silent, clk, arst_n, (fire && cfg.decrypt && first_s1) |-> (push.n == 2'd0), "decrypt message start produced a result")
	`FEI16_ASSERT(a_pair_order, clk, arst_n, (push.n == 2'd2) |-> (push.d0.is_iv && !push.d0.last && push.d1.last && !push.d1.is_iv), "IV and ciphertext pair malformed")

endmodule

// ----- hw/rtl/fei16_res_fifo.sv -----
// Small queue: takes up to two results a cycle, hands out one while ready.
// Depends on fei16_pkg and the assertion macro header.
`include "feistel16_cbc_cipher_core_macros.svh"
module fei16_res_fifo import fei16_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  push_t            push,
	output logic [CNT_W-1:0] space,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             out_res
);

	res_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign space     = CNT_W'(FIFO_DEPTH) - count_q;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.n);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			count_q  <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wr_ptr_q] <= push.d0;
		if (push.n == 2'd2)
			mem[wr_ptr_q + 1'b1] <= push.d1;
	end

	`FEI16_ASSERT(a_no_overflow, clk, arst_n, {1'b0, push.n} <= space, "results pushed beyond free space")
	`FEI16_ASSERT_ALWAYS(a_count_range, clk, count_q <= CNT_W'(FIFO_DEPTH), "queue count out of range")
	`FEI16_ASSERT(a_count_idle, clk, arst_n, (!pop && push.n == 2'd0) |=> $stable(count_q), "count moved without traffic")

endmodule

// ----- hw/rtl/feistel16_cbc_cipher_core.sv -----
// Top level of the 16-bit Feistel CBC cipher core.
// Depends on fei16_pkg, fei16_if, fei16_regs, fei16_datapath and fei16_res_fifo.
//
// Usage: blocks arrive on the "blocks" stream (data_block, first_block) and
// results leave on the "results" stream (result_block, is_iv, last); a
// transfer happens on each edge where valid and ready are both high. The APB
// port holds round_keys at address 0, init_vector at 8 and decrypt_mode at
// 16; write them only while no block is in flight.
// Path: a block taken into the input register is written into the result
// queue once the queue has room for all its results; its results then
// leave the queue in order on the results stream.
// Throughput: one block per cycle while the result queue has room. All
// eight rounds and the CBC chain update are done combinationally after the
// input register, so each block sees the chain left by the block before it.
// An encrypt message start yields two results (the IV, then the ciphertext);
// a decrypt message start only loads the chain and yields no result.
// Stall: a four-entry result queue separates the output side from the rounds.
// When the receiver holds ready low the queue fills, the input register keeps
// its block, and blocks.ready drops; nothing is lost or repeated.
// Reset: arst_n clears the queue and input register, loads the reset keys,
// sets the IV to 0x1234, selects encryption and sets the chain to 0x1234.
module feistel16_cbc_cipher_core import fei16_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	fei16_blk_if.sink         blocks,
	fei16_res_if.source       results
);

	cfg_t             cfg;
	push_t            push;
	logic [CNT_W-1:0] space;
	res_t             out_res;

	// The register file never inserts wait states.
	assign pready = 1'b1;

	fei16_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Input register, rounds and chain: one block per cycle when the queue has room.
	fei16_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (blocks.valid),
		.in_ready (blocks.ready),
		.in_data  (blocks.data_block),
		.in_first (blocks.first_block),
		.space    (space),
		.push     (push)
	);

	// The queue absorbs the two-result case and any output stall.
	fei16_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_res   (out_res)
	);

	assign results.result_block = out_res.result_block;
	assign results.is_iv        = out_res.is_iv;
	assign results.last         = out_res.last;

endmodule
